FILE: design/swd_pkg.sv
// Shared types and constants for the stack with delete-at-depth block.
// Depends on nothing; every other design file depends on it.
package swd_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned COUNT_W = 8;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_e;

endpackage

FILE: design/swd_if.sv
// Valid/ready channel interfaces for command and result beats.
// Depends on swd_pkg for the payload types.
interface swd_cmd_if;
  logic                                valid;
  logic                                ready;
  swd_pkg::cmd_e                       cmd;
  logic signed [swd_pkg::DATA_W-1:0]   value;
  logic        [swd_pkg::POS_W-1:0]    position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface swd_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [swd_pkg::DATA_W-1:0]   data;
  logic        [swd_pkg::COUNT_W-1:0]  count;
  logic                                empty_res;
  logic                                full_res;
  swd_pkg::status_e                    status;

  modport source (output valid, output data, output count, output empty_res,
                  output full_res, output status, input ready);
  modport sink   (input valid, input data, input count, input empty_res,
                  input full_res, input status, output ready);
endinterface

FILE: design/stack_with_delete_at_depth.sv
// Stack with delete-at-depth: LIFO of signed words held in one synchronous RAM.
// Steps: push and failed commands go straight to S_FIN; pop/peek read the top in S_READ;
// delete reads the victim in S_DEL, then S_SHIFT moves each entry above it down one slot.
// S_FIN waits while the output register holds a stalled result. The sequencer
// takes no new beat until the result has moved into the output register.
// Reset clears the entry count and the control and output registers; the store is not swept and no reset pass runs.
module stack_with_delete_at_depth #(
  parameter int unsigned DEPTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swd_cmd_if.sink   cmd_i,
  swd_res_if.source res_o
);
  import swd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DEL,
    S_SHIFT,
    S_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  cmd_e                op_q, op_d;
  logic [DATA_W-1:0]   res_data_q, res_data_d;
  status_e             res_status_q, res_status_d;

  // output register: parts the result side from the sequencer
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_data_q, out_data_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic                out_empty_q, out_empty_d;
  logic                out_full_q, out_full_d;
  status_e             out_status_q, out_status_d;

  logic                ram_wr_en, ram_rd_en;
  logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
  logic [DATA_W-1:0]   ram_wr_data, ram_rd_data;

  logic [MW-1:0]       pos_ext, cnt_ext;
  logic [CW-1:0]       next_rd;
  logic                more_to_move;

  swd_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign cmd_i.ready = (state_q == S_IDLE);

  assign pos_ext = MW'(cmd_i.position);
  assign cnt_ext = MW'(count_q);

  // address after the one read last cycle, and whether an entry remains above it
  assign next_rd      = CW'(rd_ptr_q) + CW'(1);
  assign more_to_move = (next_rd < count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_ptr_d     = rd_ptr_q;
    op_d         = op_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;

    out_valid_d  = out_valid_q && !res_o.ready;
    out_data_d   = out_data_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    out_full_d   = out_full_q;
    out_status_d = out_status_q;

    ram_wr_en    = 1'b0;
    ram_wr_addr  = '0;
    ram_wr_data  = '0;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          // every command goes straight to S_FIN unless it needs the read port
          op_d         = cmd_i.cmd;
          res_data_d   = '0;
          res_status_d = ST_OK;
          state_d      = S_FIN;
          case (cmd_i.cmd)
            CMD_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                res_status_d = ST_OVERFLOW;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(count_q);
                ram_wr_data = cmd_i.value;
                count_d     = count_q + CW'(1);
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (count_q == '0) begin
                res_status_d = ST_UNDERFLOW;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(count_q - CW'(1));
                state_d     = S_READ;
              end
            end
            CMD_DELETE: begin
              if (count_q == '0) begin
                res_status_d = ST_UNDERFLOW;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                res_status_d = ST_BADPOS;
              end else begin
                // slot of the victim, counted from the bottom
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(cnt_ext - pos_ext);
                rd_ptr_d    = AW'(cnt_ext - pos_ext);
                state_d     = S_DEL;
              end
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end

      S_READ: begin
        res_data_d = ram_rd_data;
        if (op_q == CMD_POP) begin
          count_d = count_q - CW'(1);
        end
        state_d = S_FIN;
      end

      S_DEL: begin
        // capture the removed word, then start walking the entries above it
        res_data_d = ram_rd_data;
        if (more_to_move) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(next_rd);
          rd_ptr_d    = AW'(next_rd);
          state_d     = S_SHIFT;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_FIN;
        end
      end

      S_SHIFT: begin
        // move the word read last cycle down one slot; the next read is two
        // slots above this write, so the ports never touch the same entry
        ram_wr_en   = 1'b1;
        ram_wr_addr = rd_ptr_q - AW'(1);
        ram_wr_data = ram_rd_data;
        if (more_to_move) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(next_rd);
          rd_ptr_d    = AW'(next_rd);
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        // hold the result until the output register is free
        if (!out_valid_q || res_o.ready) begin
          out_valid_d  = 1'b1;
          out_data_d   = res_data_q;
          out_count_d  = COUNT_W'(count_q);
          out_empty_d  = (count_q == '0);
          out_full_d   = (count_q == CW'(DEPTH));
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      rd_ptr_q     <= '0;
      op_q         <= CMD_PUSH;
      res_data_q   <= '0;
      res_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_count_q  <= '0;
      out_empty_q  <= 1'b1;
      out_full_q   <= 1'b0;
      out_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rd_ptr_q     <= rd_ptr_d;
      op_q         <= op_d;
      res_data_q   <= res_data_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
      out_count_q  <= out_count_d;
      out_empty_q  <= out_empty_d;
      out_full_q   <= out_full_d;
      out_status_q <= out_status_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.data      = out_data_q;
  assign res_o.count     = out_count_q;
  assign res_o.empty_res = out_empty_q;
  assign res_o.full_res  = out_full_q;
  assign res_o.status    = out_status_q;

endmodule

FILE: design/swd_ram.sv
// Entry store: one write port, one read port, registered read data.
// Depends on swd_pkg for the word width.
module swd_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic [swd_pkg::DATA_W-1:0]        wr_data_i,
  input  logic                              rd_en_i,
  input  logic [AW-1:0]                     rd_addr_i,
  output logic [swd_pkg::DATA_W-1:0]        rd_data_o
);
  import swd_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/swd_checker.sv
// Port-level checks on result beats of the stack with delete-at-depth.
// Depends on swd_pkg; bound to stack_with_delete_at_depth below.
module swd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [swd_pkg::DATA_W-1:0]    res_data_i,
  input logic                          res_empty_i,
  input logic                          res_full_i,
  input swd_pkg::status_e              res_status_i
);
  import swd_pkg::*;

  // hold a stalled result beat
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i)
      && $stable(res_status_i))
    else $error("stalled result beat changed");

  a_err_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i != ST_OK |-> res_data_i == '0)
    else $error("failed command returned nonzero data");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i == ST_OVERFLOW |-> res_full_i)
    else $error("overflow reported while not full");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i == ST_UNDERFLOW |-> res_empty_i)
    else $error("underflow reported while not empty");

  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(res_empty_i && res_full_i))
    else $error("empty and full flagged together");

endmodule

bind stack_with_delete_at_depth swd_checker u_swd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_data_i   (res_o.data),
  .res_empty_i  (res_o.empty_res),
  .res_full_i   (res_o.full_res),
  .res_status_i (res_o.status)
);

FILE: tb/sv/stack_with_delete_at_depth_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stack_with_delete_at_depth: random valid/ready traffic, shadow stack.
// Depends on swd_pkg, the swd_cmd_if/swd_res_if channels and the stack_with_delete_at_depth RTL.
module stack_with_delete_at_depth_tb;
  import swd_pkg::*;

  localparam int unsigned DEPTH        = 128;
  localparam int unsigned IDLE_LIMIT   = 4000; // cycles with no beat on either channel
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned RANDOM_ITEMS = 1500;

  // One result beat as the block should present it.
  typedef struct packed {
    logic signed [DATA_W-1:0]  data;
    logic        [COUNT_W-1:0] count;
    logic                      empty_res;
    logic                      full_res;
    status_e                   status;
  } stack_res_t;

  logic clk;
  logic rst_n;

  swd_cmd_if cmd_if ();
  swd_res_if res_if ();

  stack_with_delete_at_depth #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // Free-running clock, 8 ns period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the stack; updated in command order at each accepted command beat.
  logic signed [DATA_W-1:0] shadow_mem [DEPTH];
  int unsigned              shadow_cnt;

  // Results owed by the block, oldest first.
  stack_res_t pending_results [$];

  int unsigned fail_count;
  int unsigned result_beats;
  int unsigned idle_cycles;

  // Quiet flags switch off the random gaps on one side for a stretch of beats.
  bit send_quiet;
  bit recv_quiet;

  // Apply one command to the shadow stack and return the result it must produce.
  // A failing command leaves the stack untouched and reports zero data.
  function automatic stack_res_t apply_stack_cmd(input cmd_e op,
                                                 input logic signed [DATA_W-1:0] word,
                                                 input logic [POS_W-1:0] pos);
    stack_res_t  res;
    int unsigned slot;
    res        = '0;
    res.status = ST_OK;
    case (op)
      CMD_PUSH: begin
        if (shadow_cnt >= DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          shadow_mem[shadow_cnt] = word;
          shadow_cnt++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (shadow_cnt == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.data = shadow_mem[shadow_cnt-1];
          if (op == CMD_POP) shadow_cnt--;
        end
      end
      default: begin
        // Delete: empty check wins over the position check.
        if (shadow_cnt == 0) begin
          res.status = ST_UNDERFLOW;
        end else if (pos == 0 || pos > shadow_cnt) begin
          res.status = ST_BADPOS;
        end else begin
          slot     = shadow_cnt - pos;
          res.data = shadow_mem[slot];
          // Slide every entry above the removed slot down by one, order kept.
          for (int unsigned i = slot; i + 1 < shadow_cnt; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_cnt--;
        end
      end
    endcase
    res.count     = COUNT_W'(shadow_cnt);
    res.empty_res = (shadow_cnt == 0);
    res.full_res  = (shadow_cnt == DEPTH);
    return res;
  endfunction

  // Send one command beat. Valid stays high straight into the next beat when the drawn gap
  // is zero, so it is never lowered and raised within one time step.
  task automatic issue_cmd(input cmd_e op, input logic signed [DATA_W-1:0] word,
                           input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.cmd      <= op;
    cmd_if.value    <= word;
    cmd_if.position <= pos;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    // Beat taken at this edge: predict now, in acceptance order.
    pending_results.push_back(apply_stack_cmd(op, word, pos));
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic flag_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("mismatch beat %0d field %s: expected %0d, got %0d",
                 result_beats, name, exp_v, act_v);
    end
  endtask

  // Pop, peek and delete on an empty stack all underflow; position is not looked at.
  task automatic test_empty_stack();
    issue_cmd(CMD_POP, 32'sd0, 8'd0);
    issue_cmd(CMD_PEEK, 32'sd0, 8'd0);
    issue_cmd(CMD_DELETE, 32'sd0, 8'd1);
    issue_cmd(CMD_DELETE, 32'sd0, 8'd0);
  endtask

  // Push the corner words of the 32-bit range plus alternating patterns.
  task automatic test_push_extremes();
    issue_cmd(CMD_PUSH, 32'sh8000_0000, 8'd0);
    issue_cmd(CMD_PUSH, 32'sh7FFF_FFFF, 8'd255);
    issue_cmd(CMD_PUSH, 32'sh0000_0000, 8'd0);
    issue_cmd(CMD_PUSH, 32'shFFFF_FFFF, 8'd128);
    issue_cmd(CMD_PUSH, 32'sh5A5A_5A5A, 8'd0);
    issue_cmd(CMD_PUSH, 32'shA5A5_A5A5, 8'd0);
  endtask

  // Peek must not move the top; pop must.
  task automatic test_peek_pop();
    issue_cmd(CMD_PEEK, 32'sd0, 8'd0);
    issue_cmd(CMD_POP, 32'sd0, 8'd0);
    issue_cmd(CMD_PEEK, 32'sd0, 8'd0);
  endtask

  // Bad positions first, then delete at bottom, top and middle, then drain to empty.
  task automatic test_delete_position();
    issue_cmd(CMD_DELETE, 32'sd0, 8'd0);
    issue_cmd(CMD_DELETE, 32'sd0, POS_W'(shadow_cnt + 1));
    issue_cmd(CMD_DELETE, 32'sd0, 8'd255);
    issue_cmd(CMD_DELETE, 32'sd0, POS_W'(shadow_cnt));
    issue_cmd(CMD_DELETE, 32'sd0, 8'd1);
    issue_cmd(CMD_DELETE, 32'sd0, 8'd2);
    issue_cmd(CMD_POP, 32'sd0, 8'd0);
    issue_cmd(CMD_POP, 32'sd0, 8'd0);
    issue_cmd(CMD_POP, 32'sd0, 8'd0);
  endtask

  // Fill to DEPTH, overflow, then delete the deepest entry (longest walk) at full.
  task automatic test_full_stack();
    while (shadow_cnt < DEPTH) issue_cmd(CMD_PUSH, $urandom, POS_W'($urandom));
    issue_cmd(CMD_PUSH, 32'sh1234_5678, 8'd0);
    issue_cmd(CMD_PEEK, 32'sd0, 8'd0);
    issue_cmd(CMD_DELETE, 32'sd0, POS_W'(DEPTH));
    issue_cmd(CMD_DELETE, 32'sd0, POS_W'(DEPTH));
    issue_cmd(CMD_PUSH, $urandom, 8'd0);
    issue_cmd(CMD_POP, 32'sd0, 8'd0);
  endtask

  // Random traffic in stretches that grow, shrink or hover, so the count sweeps its range.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned      mode;
    int unsigned      push_pct;
    int unsigned      roll;
    cmd_e             op;
    logic signed [DATA_W-1:0] word;
    logic [POS_W-1:0] pos;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 100 == 0) begin
        mode       = $urandom_range(0, 2);
        send_quiet = ($urandom_range(0, 4) == 0);
        recv_quiet = ($urandom_range(0, 4) == 0);
      end
      // Stall the sender now and then until the block has caught up completely.
      if (k % 250 == 249) drain_results();
      push_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 48;
      roll     = $urandom_range(0, 99);
      if (roll < push_pct) begin
        op = CMD_PUSH;
      end else begin
        roll = $urandom_range(0, 9);
        op   = (roll < 4) ? CMD_POP : (roll < 6) ? CMD_PEEK : CMD_DELETE;
      end
      word = $urandom;
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0:       word = 32'sh8000_0000;
          1:       word = 32'sh7FFF_FFFF;
          2:       word = 32'sh0000_0000;
          default: word = 32'shFFFF_FFFF;
        endcase
      end
      roll = $urandom_range(0, 9);
      if (roll < 8 && shadow_cnt != 0)
        pos = POS_W'($urandom_range(1, shadow_cnt));
      else if (roll == 8)
        pos = ($urandom_range(0, 1) == 0) ? '0 : POS_W'(shadow_cnt + 1);
      else
        pos = POS_W'($urandom);
      issue_cmd(op, word, pos);
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  // Result sink: draw a stall before each beat, then hold ready until one beat is taken.
  int unsigned stall;
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = recv_quiet ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  // Check every result beat against the oldest owed result, field by field.
  stack_res_t owed;
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      result_beats++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result beat %0d: data %0d count %0d status %0d",
                   result_beats, res_if.data, res_if.count, res_if.status);
      end else begin
        owed = pending_results.pop_front();
        flag_field("data", owed.data, res_if.data);
        flag_field("count", owed.count, res_if.count);
        flag_field("empty_res", owed.empty_res, res_if.empty_res);
        flag_field("full_res", owed.full_res, res_if.full_res);
        flag_field("status", owed.status, res_if.status);
      end
    end
  end

  // Watchdog: a long stretch with no beat on either channel means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cmd_if.valid    <= 1'b0;
    cmd_if.cmd      <= CMD_PUSH;
    cmd_if.value    <= '0;
    cmd_if.position <= '0;
    shadow_cnt   = 0;
    fail_count   = 0;
    result_beats = 0;
    send_quiet   = 1'b0;
    recv_quiet   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_push_extremes();
    test_peek_pop();
    test_delete_position();
    test_full_stack();
    test_random_traffic(RANDOM_ITEMS);

    // Let the tail drain, then give a full delete walk of slack to catch stray beats.
    drain_results();
    repeat (DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
